/* rtl/pvge_pkg.sv */
// Package for the PV gradient parameter estimator.
// Holds register indexes, formats and saturation helpers; no dependencies.
package pvge_pkg;

  localparam int SampleFracBits = 16;
  localparam int ParamFracBits  = 32;
  localparam int SampleW        = 32;
  localparam int ParamW         = 48;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 48;

  localparam logic [CfgIdxW-1:0] RegIgLevel    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGain11     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGain12     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGain21     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGain22     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAlphaStart = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBetaStart  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegStepSize   = 3'd7;

  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  // Datapath operation selects issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOG_STEP,
    OP_LOG_SCALE,
    OP_VA,
    OP_ERR,
    OP_G1,
    OP_G2,
    OP_U1,
    OP_U2,
    OP_D1,
    OP_D2,
    OP_UPDATE
  } op_t;

  // Multiplies run over phases 0..2 (partial products) and 3 (result).
  typedef struct packed {
    op_t        op;
    logic [1:0] phase;
    logic       restart;
  } cmd_t;

  typedef struct packed {
    logic domain_err;
  } status_t;

  // Clamp a 128-bit signed value to 48 bits.
  function automatic logic signed [ParamW-1:0] sat48(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (ParamW - 1)) - 128'sd1;
    lo = -(128'sd1 <<< (ParamW - 1));
    if (v > hi) begin
      return hi[ParamW-1:0];
    end else if (v < lo) begin
      return lo[ParamW-1:0];
    end
    return v[ParamW-1:0];
  endfunction

endpackage

/* rtl/pvge_ctrl.sv */
// Controller for the PV gradient parameter estimator.
// Sequences the datapath; multiplies span phases. Uses pvge_pkg.
module pvge_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              in_restart,
  input  logic              out_fire,
  input  pvge_pkg::status_t status,
  output logic              busy,
  output logic              out_valid,
  output pvge_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOG   = 3'd1;
  localparam logic [2:0] S_MATH  = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [4:0] count;
  logic [4:0] count_next;
  logic [1:0] sub;
  logic [1:0] sub_next;
  logic       restart;
  logic       is_mul;

  pvge_pkg::op_t math_ops [10];
  pvge_pkg::op_t math_op;
  assign math_ops[0] = pvge_pkg::OP_LOG_SCALE;
  assign math_ops[1] = pvge_pkg::OP_VA;
  assign math_ops[2] = pvge_pkg::OP_ERR;
  assign math_ops[3] = pvge_pkg::OP_G1;
  assign math_ops[4] = pvge_pkg::OP_G2;
  assign math_ops[5] = pvge_pkg::OP_U1;
  assign math_ops[6] = pvge_pkg::OP_U2;
  assign math_ops[7] = pvge_pkg::OP_D1;
  assign math_ops[8] = pvge_pkg::OP_D2;
  assign math_ops[9] = pvge_pkg::OP_UPDATE;

  always_comb begin
    math_op = math_ops[count[3:0]];
    case (math_op) inside
      pvge_pkg::OP_VA, pvge_pkg::OP_G1, pvge_pkg::OP_G2, pvge_pkg::OP_U1,
      pvge_pkg::OP_U2, pvge_pkg::OP_D1, pvge_pkg::OP_D2: is_mul = 1'b1;
      default: is_mul = 1'b0;
    endcase
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    sub_next    = sub;
    cmd.op      = pvge_pkg::OP_NONE;
    cmd.phase   = '0;
    cmd.restart = in_restart;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op     = pvge_pkg::OP_LOAD;
          state_next = S_LOG;
          count_next = '0;
        end
      end
      S_LOG: begin
        cmd.restart = restart;
        if (status.domain_err) begin
          state_next = S_OUT;
        end else begin
          cmd.op     = pvge_pkg::OP_LOG_STEP;
          count_next = count + 5'd1;
          if (count == 5'd31) begin
            state_next = S_MATH;
            count_next = '0;
          end
        end
      end
      S_MATH: begin
        cmd.op    = math_op;
        cmd.phase = sub;
        // Hold a multiply for four phases before advancing.
        if (is_mul && sub != 2'd3) begin
          sub_next = sub + 2'd1;
        end else begin
          sub_next   = '0;
          count_next = count + 5'd1;
          if (count == 5'd9) begin
            state_next = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      sub   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      sub   <= sub_next;
    end
    if (in_fire) begin
      restart <= in_restart;
    end
  end

  assign busy      = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

/* rtl/pvge_datapath.sv */
// Datapath of the PV gradient parameter estimator: config registers, log
// squaring unit, one shared multiplier and the parameter state. Uses pvge_pkg.
module pvge_datapath #(
  parameter int SAMPLE_FRAC_BITS = pvge_pkg::SampleFracBits,
  parameter int PARAM_FRAC_BITS  = pvge_pkg::ParamFracBits
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pvge_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [pvge_pkg::CfgDataW-1:0]         cfg_data,
  input  logic signed [pvge_pkg::SampleW-1:0]   voltage_in,
  input  logic signed [pvge_pkg::SampleW-1:0]   current_in,
  input  pvge_pkg::cmd_t                        cmd,
  output pvge_pkg::status_t                     status,
  output logic signed [pvge_pkg::ParamW-1:0]    alpha_out,
  output logic signed [pvge_pkg::ParamW-1:0]    beta_out,
  output logic signed [pvge_pkg::SampleW-1:0]   voltage_echo,
  output logic signed [pvge_pkg::SampleW-1:0]   current_echo
);

  localparam int PW = pvge_pkg::ParamW;
  localparam int SW = pvge_pkg::SampleW;
  localparam logic signed [33:0] Ln2Q32x = 34'sd2977044472;

  logic signed [SW-1:0] ig_level, gain_11, gain_12, gain_21, gain_22;
  logic signed [PW-1:0] alpha_start, beta_start;
  logic        [PW-1:0] step_size;

  logic signed [PW-1:0] alpha, beta;
  logic signed [SW-1:0] volt, curr;
  logic                 derr;
  logic [5:0]           k;
  logic [32:0]          m;
  logic [31:0]          frac;
  logic signed [PW-1:0] y, va, e, g1, g2, u1, u2, d1, d2;

  // Shared floor(a*b/2^sh) with 48-bit saturation. Magnitudes are multiplied
  // 48x16 per phase into an accumulator; phase 3 applies sign, shift and clamp.
  logic signed [63:0]  mul_a, mul_b;
  logic [6:0]          mul_sh;
  logic                mul_op;
  logic                mul_last;
  logic                mul_neg;
  logic signed [63:0]  mul_abs_a, mul_abs_b;
  logic [15:0]         mul_digit;
  logic [63:0]         mul_pp;
  logic [95:0]         mul_part;
  logic [95:0]         mul_acc;
  logic signed [127:0] mul_p;
  logic signed [PW-1:0] mul_r;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = 7'(SAMPLE_FRAC_BITS);
    mul_op = 1'b1;
    case (cmd.op)
      pvge_pkg::OP_VA: begin mul_a = 64'(volt); mul_b = 64'(alpha); end
      pvge_pkg::OP_G1: begin mul_a = 64'(gain_11); mul_b = 64'(volt); end
      pvge_pkg::OP_G2: begin mul_a = 64'(gain_21); mul_b = 64'(volt); end
      pvge_pkg::OP_U1: begin mul_a = 64'(g1); mul_b = 64'(e); end
      pvge_pkg::OP_U2: begin mul_a = 64'(g2); mul_b = 64'(e); end
      pvge_pkg::OP_D1: begin
        mul_a = 64'(u1); mul_b = $signed({16'd0, step_size}); mul_sh = 7'd48;
      end
      pvge_pkg::OP_D2: begin
        mul_a = 64'(u2); mul_b = $signed({16'd0, step_size}); mul_sh = 7'd48;
      end
      default: mul_op = 1'b0;
    endcase
    mul_last  = mul_op && (cmd.phase == 2'd3);
    mul_neg   = mul_a[63] ^ mul_b[63];
    mul_abs_a = mul_a[63] ? -mul_a : mul_a;
    mul_abs_b = mul_b[63] ? -mul_b : mul_b;
    case (cmd.phase)
      2'd0:    mul_digit = mul_abs_b[15:0];
      2'd1:    mul_digit = mul_abs_b[31:16];
      default: mul_digit = mul_abs_b[47:32];
    endcase
    mul_pp   = {16'd0, mul_abs_a[47:0]} * {48'd0, mul_digit};
    mul_part = {32'd0, mul_pp} << {cmd.phase, 4'd0};
    mul_p    = (mul_neg ? -$signed({32'd0, mul_acc}) : $signed({32'd0, mul_acc}))
               >>> mul_sh;
    mul_r    = pvge_pkg::sat48(mul_p);
  end

  // Leading one and normalization of ig - current; squaring of m; log scaling.
  logic signed [SW:0] diff;
  logic [5:0]         lead;
  logic [32:0]        norm;
  logic [65:0]        sq;
  logic signed [127:0] yfull;
  logic signed [127:0] tmp;

  always_comb begin
    diff = 33'(ig_level) - 33'(current_in);
    lead = '0;
    for (int i = 0; i < SW; i++) begin
      if (diff[i]) lead = 6'(i);
    end
    norm = 33'(diff[31:0]) << (6'd31 - lead);
    sq   = 66'(m) * 66'(m);
    yfull = (128'(signed'({1'b0, k})) - 128'(SAMPLE_FRAC_BITS)) * 128'(Ln2Q32x)
          + 128'((64'(frac) * 64'(pvge_pkg::Ln2Q32)) >> 32);
    if (PARAM_FRAC_BITS >= 32) begin
      tmp = yfull <<< (PARAM_FRAC_BITS - 32);
    end else begin
      tmp = yfull >>> (32 - PARAM_FRAC_BITS);
    end
  end

  logic [32:0] sq_sh;
  assign sq_sh = 33'(sq >> 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      ig_level    <= 32'sd261489;
      gain_11     <= 32'sd6554;
      gain_12     <= '0;
      gain_21     <= '0;
      gain_22     <= 32'sd6553600;
      alpha_start <= 48'sd2362232013;
      beta_start  <= -48'sd55834574848;
      step_size   <= 48'd281474977;
      alpha       <= '0;
      beta        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pvge_pkg::RegIgLevel:    ig_level    <= cfg_data[SW-1:0];
          pvge_pkg::RegGain11:     gain_11     <= cfg_data[SW-1:0];
          pvge_pkg::RegGain12:     gain_12     <= cfg_data[SW-1:0];
          pvge_pkg::RegGain21:     gain_21     <= cfg_data[SW-1:0];
          pvge_pkg::RegGain22:     gain_22     <= cfg_data[SW-1:0];
          pvge_pkg::RegAlphaStart: alpha_start <= cfg_data;
          pvge_pkg::RegBetaStart:  beta_start  <= cfg_data;
          pvge_pkg::RegStepSize:   step_size   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == pvge_pkg::OP_LOAD && cmd.restart) begin
        alpha <= alpha_start;
        beta  <= beta_start;
      end
      if (cmd.op == pvge_pkg::OP_UPDATE) begin
        alpha <= pvge_pkg::sat48(128'(alpha) + 128'(d1));
        beta  <= pvge_pkg::sat48(128'(beta) + 128'(d2));
      end
    end
    if (mul_op && !mul_last) begin
      mul_acc <= (cmd.phase == 2'd0) ? mul_part : mul_acc + mul_part;
    end
    case (cmd.op)
      pvge_pkg::OP_LOAD: begin
        volt <= voltage_in;
        curr <= current_in;
        derr <= (diff <= 0);
        k    <= lead;
        m    <= norm;
        frac <= '0;
      end
      pvge_pkg::OP_LOG_STEP: begin
        // Square, then halve and emit a one when the square reaches two.
        if (sq_sh[32]) begin
          m    <= sq_sh >> 1;
          frac <= {frac[30:0], 1'b1};
        end else begin
          m    <= sq_sh;
          frac <= {frac[30:0], 1'b0};
        end
      end
      pvge_pkg::OP_LOG_SCALE: y  <= tmp[PW-1:0];
      pvge_pkg::OP_VA:        if (mul_last) va <= mul_r;
      pvge_pkg::OP_ERR:       e  <= pvge_pkg::sat48(128'(y) - 128'(va) - 128'(beta));
      pvge_pkg::OP_G1: if (mul_last) g1 <= pvge_pkg::sat48(128'(mul_p) + 128'(gain_12));
      pvge_pkg::OP_G2: if (mul_last) g2 <= pvge_pkg::sat48(128'(mul_p) + 128'(gain_22));
      pvge_pkg::OP_U1: if (mul_last) u1 <= mul_r;
      pvge_pkg::OP_U2: if (mul_last) u2 <= mul_r;
      pvge_pkg::OP_D1: if (mul_last) d1 <= mul_r;
      pvge_pkg::OP_D2: if (mul_last) d2 <= mul_r;
      default: ;
    endcase
  end

  assign status.domain_err = derr;
  assign alpha_out    = alpha;
  assign beta_out     = beta;
  assign voltage_echo = volt;
  assign current_echo = curr;

endmodule

/* rtl/pv_gradient_parameter_estimator.sv */
// PV gradient parameter estimator, top level.
// A request runs through a load, 32 log squaring steps and the arithmetic
// steps (seven multiplies and three single steps); on a domain error the
// controller goes from the load straight to the output state.
// Throughput: one item at a time, set by the log squaring loop and the
// multiplies; a new sample is taken only once the result is accepted.
// Reset (rst, synchronous): parameters cleared, registers to defaults.
module pv_gradient_parameter_estimator #(
  parameter int SAMPLE_FRAC_BITS = pvge_pkg::SampleFracBits,
  parameter int PARAM_FRAC_BITS  = pvge_pkg::ParamFracBits
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // voltage_sample, current_sample
  input  logic         s_tuser,   // restart
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // alpha_out, beta_out, voltage_echo, current_echo
  output logic         m_tuser,   // domain_error
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  pvge_pkg::cmd_t    cmd;
  pvge_pkg::status_t status;
  logic              busy;
  logic              in_fire;
  logic signed [47:0] a_o, b_o;
  logic signed [31:0] v_o, c_o;

  assign s_tready  = !busy;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  pvge_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_restart(s_tuser),
    .out_fire  (m_tvalid && m_tready),
    .status    (status),
    .busy      (busy),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  pvge_datapath #(
    .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .voltage_in  (s_tdata[31:0]),
    .current_in  (s_tdata[63:32]),
    .cmd         (cmd),
    .status      (status),
    .alpha_out   (a_o),
    .beta_out    (b_o),
    .voltage_echo(v_o),
    .current_echo(c_o)
  );

  assign m_tdata = {c_o, v_o, b_o, a_o};
  assign m_tuser = status.domain_err;

endmodule
